### rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VBLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VBLP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/vblp_pkg.sv
// Shared types, codes and neighbour helpers of the voxel light block.
`timescale 1ns / 1ps

package vblp_pkg;

    // Item opcodes.
    localparam logic [2:0] OP_WR_LIGHT   = 3'd0;
    localparam logic [2:0] OP_WR_OPACITY = 3'd1;
    localparam logic [2:0] OP_WR_SOURCE  = 3'd2;
    localparam logic [2:0] OP_PUSH_DEC   = 3'd3;
    localparam logic [2:0] OP_PUSH_INC   = 3'd4;
    localparam logic [2:0] OP_RUN        = 3'd5;
    localparam logic [2:0] OP_RD_LIGHT   = 3'd6;
    localparam logic [2:0] OP_UNUSED     = 3'd7;

    localparam logic [19:0] COUNT_MAX = 20'hFFFFF;
    localparam logic [5:0]  DIR_ALL   = 6'h3F;
    localparam logic [2:0]  DIR_LAST  = 3'd5;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_EXEC,
        CMD_DEC_FETCH,
        CMD_DEC_ENTRY,
        CMD_DEC_DIR,
        CMD_DEC_NB,
        CMD_INC_FETCH,
        CMD_INC_ENTRY,
        CMD_INC_CUR,
        CMD_INC_DIR,
        CMD_INC_NB,
        CMD_FINISH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_run;
        logic dec_avail;
        logic inc_avail;
        logic dir_hit;
        logic dir_last;
        logic cur_ok;
    } dp_status_t;

    // True when the step from pos in direction dir stays inside the section.
    // Directions are -x, +x, -y, +y, -z, +z.
    function automatic logic nb_valid(input logic [11:0] pos, input logic [2:0] dir);
        logic ok;
        ok = 1'b0;
        case (dir)
            3'd0: ok = (pos[3:0] != 4'd0);
            3'd1: ok = (pos[3:0] != 4'd15);
            3'd2: ok = (pos[11:8] != 4'd0);
            3'd3: ok = (pos[11:8] != 4'd15);
            3'd4: ok = (pos[7:4] != 4'd0);
            3'd5: ok = (pos[7:4] != 4'd15);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [11:0] nb_pos(input logic [11:0] pos, input logic [2:0] dir);
        logic [11:0] n;
        n = pos;
        case (dir)
            3'd0: n = pos - 12'd1;
            3'd1: n = pos + 12'd1;
            3'd2: n = pos - 12'd256;
            3'd3: n = pos + 12'd256;
            3'd4: n = pos - 12'd16;
            3'd5: n = pos + 12'd16;
            default: n = pos;
        endcase
        return n;
    endfunction

    // One-hot enable of the direction pointing back the way we came.
    function automatic logic [5:0] back_onehot(input logic [2:0] dir);
        logic [5:0] m;
        m = 6'd0;
        case (dir)
            3'd0: m = 6'b000010;
            3'd1: m = 6'b000001;
            3'd2: m = 6'b001000;
            3'd3: m = 6'b000100;
            3'd4: m = 6'b100000;
            3'd5: m = 6'b010000;
            default: m = 6'd0;
        endcase
        return m;
    endfunction

endpackage

### rtl/vblp_in_if.sv
// Handshake channel that carries one command word into the block.
`timescale 1ns / 1ps

interface vblp_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [11:0] cell_index;
    logic [3:0]  cell_value;
    logic [11:0] seed_flags;

    modport source (output valid, output opcode, output cell_index,
                    output cell_value, output seed_flags, input ready);
    modport sink   (input valid, input opcode, input cell_index,
                    input cell_value, input seed_flags, output ready);
endinterface

### rtl/vblp_out_if.sv
// Handshake channel that carries one result word out of the block.
`timescale 1ns / 1ps

interface vblp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  read_value;
    logic [19:0] changed_count;
    logic        queue_overflow;
    logic        run_done;

    modport source (output valid, output read_value, output changed_count,
                    output queue_overflow, output run_done, input ready);
    modport sink   (input valid, input read_value, input changed_count,
                    input queue_overflow, input run_done, output ready);
endinterface

### rtl/vblp_ctrl.sv
// Sequencer that steps the datapath through loads, reads and the two flood passes.
`timescale 1ns / 1ps

module vblp_ctrl
    import vblp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    output logic       out_valid,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [12:0] {
        S_IDLE      = 13'b0000000000001,
        S_EXEC      = 13'b0000000000010,
        S_DEC_FETCH = 13'b0000000000100,
        S_DEC_ENTRY = 13'b0000000001000,
        S_DEC_DIR   = 13'b0000000010000,
        S_DEC_NB    = 13'b0000000100000,
        S_INC_FETCH = 13'b0000001000000,
        S_INC_ENTRY = 13'b0000010000000,
        S_INC_CUR   = 13'b0000100000000,
        S_INC_DIR   = 13'b0001000000000,
        S_INC_NB    = 13'b0010000000000,
        S_FINISH    = 13'b0100000000000,
        S_RESP      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_load  = (state_reg == S_RESP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next   = state_reg;
        cmd.op       = CMD_NONE;
        cmd.out_load = out_load;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LATCH;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.op     = CMD_EXEC;
                state_next = status.is_run ? S_DEC_FETCH : S_RESP;
            end
            S_DEC_FETCH:
            begin
                cmd.op     = CMD_DEC_FETCH;
                state_next = status.dec_avail ? S_DEC_ENTRY : S_INC_FETCH;
            end
            S_DEC_ENTRY:
            begin
                cmd.op     = CMD_DEC_ENTRY;
                state_next = S_DEC_DIR;
            end
            S_DEC_DIR:
            begin
                cmd.op = CMD_DEC_DIR;
                if (status.dir_hit)
                    state_next = S_DEC_NB;
                else if (status.dir_last)
                    state_next = S_DEC_FETCH;
            end
            S_DEC_NB:
            begin
                cmd.op     = CMD_DEC_NB;
                state_next = status.dir_last ? S_DEC_FETCH : S_DEC_DIR;
            end
            S_INC_FETCH:
            begin
                cmd.op     = CMD_INC_FETCH;
                state_next = status.inc_avail ? S_INC_ENTRY : S_FINISH;
            end
            S_INC_ENTRY:
            begin
                cmd.op     = CMD_INC_ENTRY;
                state_next = S_INC_CUR;
            end
            S_INC_CUR:
            begin
                cmd.op     = CMD_INC_CUR;
                state_next = status.cur_ok ? S_INC_DIR : S_INC_FETCH;
            end
            S_INC_DIR:
            begin
                cmd.op = CMD_INC_DIR;
                if (status.dir_hit)
                    state_next = S_INC_NB;
                else if (status.dir_last)
                    state_next = S_INC_FETCH;
            end
            S_INC_NB:
            begin
                cmd.op     = CMD_INC_NB;
                state_next = status.dir_last ? S_INC_FETCH : S_INC_DIR;
            end
            S_FINISH:
            begin
                cmd.op     = CMD_FINISH;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/vblp_dp.sv
// Grids, queues, counters and result register of the voxel light block.
`timescale 1ns / 1ps

module vblp_dp
    import vblp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  logic [2:0]  opcode,
    input  logic [11:0] cell_index,
    input  logic [3:0]  cell_value,
    input  logic [11:0] seed_flags,
    output logic [3:0]  read_value,
    output logic [19:0] changed_count,
    output logic        queue_overflow,
    output logic        run_done
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QW-1:0] QFULL = QW'(QUEUE_DEPTH);

    logic [3:0]  lt_mem  [4096];
    logic [3:0]  op_mem  [4096];
    logic [3:0]  src_mem [4096];
    logic [23:0] dq_mem  [QUEUE_DEPTH];
    logic [23:0] iq_mem  [QUEUE_DEPTH];

    logic [3:0]  lt_rdata, op_rdata, src_rdata;
    logic [23:0] dq_rdata, iq_rdata;

    logic [2:0]  op_reg;
    logic [11:0] idx_reg, flags_reg;
    logic [3:0]  val_reg;
    logic [11:0] pos_reg, fl_reg, nb_reg;
    logic [2:0]  dir_reg;
    logic [5:0]  back_reg;

    logic [QW-1:0] dq_head_reg, dq_tail_reg, iq_head_reg, iq_tail_reg;
    logic [19:0]   count_reg;
    logic          ovf_reg;

    logic [3:0]  out_rd_reg;
    logic [19:0] out_count_reg;
    logic        out_ovf_reg, out_done_reg;

    logic        lt_we, lt_re, op_we, op_re, src_we, src_re;
    logic [11:0] lt_waddr, lt_raddr, nb_raddr;
    logic [3:0]  lt_wdata;
    logic        dq_push, iq_push, bump;
    logic [23:0] dq_wdata, iq_wdata;

    logic [3:0]  lvl, nl, cur, op_eff, k_lvl;
    logic [11:0] nb_n;
    logic [5:0]  dir_en;
    logic        dir_hit, dec_clear, dec_bright, force_set, inc_set;
    logic [4:0]  nb_sum;

    assign lvl     = fl_reg[3:0];
    assign nl      = lt_rdata;
    assign nb_n    = nb_pos(pos_reg, dir_reg);
    assign dir_en  = fl_reg[9:4];
    assign dir_hit = dir_en[dir_reg] && nb_valid(pos_reg, dir_reg);

    assign dec_clear  = (nl != 4'd0) && (nl < lvl);
    assign dec_bright = (nl != 4'd0) && (nl >= lvl);

    assign force_set = fl_reg[11] && (lt_rdata < lvl);
    assign cur       = force_set ? lvl : lt_rdata;

    // Opacity zero still costs one level per step.
    assign op_eff = (op_rdata == 4'd0) ? 4'd1 : op_rdata;
    assign nb_sum = {1'b0, nl} + {1'b0, op_eff};
    assign inc_set = ({1'b0, lvl} > nb_sum);
    assign k_lvl  = lvl - op_eff;

    assign status.is_run    = (op_reg == OP_RUN);
    assign status.dec_avail = (dq_head_reg < dq_tail_reg);
    assign status.inc_avail = (iq_head_reg < iq_tail_reg);
    assign status.dir_hit   = dir_hit;
    assign status.dir_last  = (dir_reg == DIR_LAST);
    assign status.cur_ok    = (cur == lvl);

    always_comb
    begin
        lt_we    = 1'b0;
        lt_waddr = nb_reg;
        lt_wdata = 4'd0;
        lt_re    = 1'b0;
        lt_raddr = nb_n;
        op_we    = 1'b0;
        op_re    = 1'b0;
        src_we   = 1'b0;
        src_re   = 1'b0;
        nb_raddr = nb_n;
        dq_push  = 1'b0;
        dq_wdata = {idx_reg, flags_reg};
        iq_push  = 1'b0;
        iq_wdata = {idx_reg, flags_reg};
        bump     = 1'b0;
        case (cmd.op)
            CMD_EXEC:
            begin
                case (op_reg)
                    OP_WR_LIGHT:
                    begin
                        lt_we    = 1'b1;
                        lt_waddr = idx_reg;
                        lt_wdata = val_reg;
                    end
                    OP_WR_OPACITY: op_we   = 1'b1;
                    OP_WR_SOURCE:  src_we  = 1'b1;
                    OP_PUSH_DEC:   dq_push = 1'b1;
                    OP_PUSH_INC:   iq_push = 1'b1;
                    OP_RD_LIGHT:
                    begin
                        lt_re    = 1'b1;
                        lt_raddr = idx_reg;
                    end
                    default: ;
                endcase
            end
            CMD_DEC_DIR:
            begin
                lt_re  = dir_hit;
                src_re = dir_hit;
            end
            CMD_DEC_NB:
            begin
                if (dec_clear)
                begin
                    lt_we    = 1'b1;
                    bump     = 1'b1;
                    dq_push  = (src_rdata < nl);
                    dq_wdata = {nb_reg, 2'b00, ~back_reg, nl};
                    iq_push  = (src_rdata != 4'd0);
                    iq_wdata = {nb_reg, 2'b10, DIR_ALL, src_rdata};
                end
                else if (dec_bright)
                begin
                    iq_push  = 1'b1;
                    iq_wdata = {nb_reg, 2'b00, back_reg, nl};
                end
            end
            CMD_INC_ENTRY:
            begin
                lt_re    = 1'b1;
                lt_raddr = iq_rdata[23:12];
            end
            CMD_INC_CUR:
            begin
                if (force_set)
                begin
                    lt_we    = 1'b1;
                    lt_waddr = pos_reg;
                    lt_wdata = lvl;
                    bump     = 1'b1;
                end
            end
            CMD_INC_DIR:
            begin
                lt_re = dir_hit;
                op_re = dir_hit;
            end
            CMD_INC_NB:
            begin
                if (inc_set)
                begin
                    lt_we    = 1'b1;
                    lt_wdata = k_lvl;
                    bump     = 1'b1;
                    iq_push  = (k_lvl > 4'd1);
                    iq_wdata = {nb_reg, 2'b00, ~back_reg, k_lvl};
                end
            end
            default: ;
        endcase
    end

    // Grid memories.
    always_ff @(posedge clk)
    begin
        if (lt_we)
            lt_mem[lt_waddr] <= lt_wdata;
        if (lt_re)
            lt_rdata <= lt_mem[lt_raddr];
        if (op_we)
            op_mem[idx_reg] <= val_reg;
        if (op_re)
            op_rdata <= op_mem[nb_raddr];
        if (src_we)
            src_mem[idx_reg] <= val_reg;
        if (src_re)
            src_rdata <= src_mem[nb_raddr];
    end

    // Queue memories; a push only lands while the tail is below the depth.
    always_ff @(posedge clk)
    begin
        if (dq_push && (dq_tail_reg < QFULL))
            dq_mem[dq_tail_reg[AW-1:0]] <= dq_wdata;
        if (cmd.op == CMD_DEC_FETCH && status.dec_avail)
            dq_rdata <= dq_mem[dq_head_reg[AW-1:0]];
        if (iq_push && (iq_tail_reg < QFULL))
            iq_mem[iq_tail_reg[AW-1:0]] <= iq_wdata;
        if (cmd.op == CMD_INC_FETCH && status.inc_avail)
            iq_rdata <= iq_mem[iq_head_reg[AW-1:0]];
    end

    // Item capture, walk registers and the result word.
    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LATCH)
        begin
            op_reg    <= opcode;
            idx_reg   <= cell_index;
            val_reg   <= cell_value;
            flags_reg <= seed_flags;
        end
        case (cmd.op)
            CMD_DEC_ENTRY:
            begin
                pos_reg <= dq_rdata[23:12];
                fl_reg  <= dq_rdata[11:0];
                dir_reg <= 3'd0;
            end
            CMD_INC_ENTRY:
            begin
                pos_reg <= iq_rdata[23:12];
                fl_reg  <= iq_rdata[11:0];
            end
            CMD_INC_CUR:
            begin
                dir_reg <= 3'd0;
            end
            CMD_DEC_DIR, CMD_INC_DIR:
            begin
                if (dir_hit)
                begin
                    nb_reg   <= nb_n;
                    back_reg <= back_onehot(dir_reg);
                end
                else
                begin
                    dir_reg <= dir_reg + 3'd1;
                end
            end
            CMD_DEC_NB, CMD_INC_NB:
            begin
                dir_reg <= dir_reg + 3'd1;
            end
            default: ;
        endcase
        if (cmd.out_load)
        begin
            out_rd_reg    <= (op_reg == OP_RD_LIGHT) ? lt_rdata : 4'd0;
            out_count_reg <= count_reg;
            out_ovf_reg   <= ovf_reg;
            out_done_reg  <= (op_reg == OP_RUN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dq_head_reg <= '0;
            dq_tail_reg <= '0;
            iq_head_reg <= '0;
            iq_tail_reg <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.op == CMD_FINISH)
            begin
                dq_head_reg <= '0;
                dq_tail_reg <= '0;
                iq_head_reg <= '0;
                iq_tail_reg <= '0;
            end
            else
            begin
                if (cmd.op == CMD_DEC_FETCH && status.dec_avail)
                    dq_head_reg <= dq_head_reg + QW'(1);
                if (cmd.op == CMD_INC_FETCH && status.inc_avail)
                    iq_head_reg <= iq_head_reg + QW'(1);
                if (dq_push)
                begin
                    if (dq_tail_reg < QFULL)
                        dq_tail_reg <= dq_tail_reg + QW'(1);
                    else
                        ovf_reg <= 1'b1;
                end
                if (iq_push)
                begin
                    if (iq_tail_reg < QFULL)
                        iq_tail_reg <= iq_tail_reg + QW'(1);
                    else
                        ovf_reg <= 1'b1;
                end
            end
            if (cmd.op == CMD_EXEC && op_reg == OP_RUN)
                count_reg <= '0;
            else if (bump && count_reg != COUNT_MAX)
                count_reg <= count_reg + 20'd1;
        end
    end

    assign read_value     = out_rd_reg;
    assign changed_count  = out_count_reg;
    assign queue_overflow = out_ovf_reg;
    assign run_done       = out_done_reg;

endmodule

### rtl/voxel_block_light_propagation_top.sv
// Top level of the voxel block light propagation engine.
`timescale 1ns / 1ps

// This block holds one 16x16x16 section of 4-bit light, opacity and source
// grids plus a decrease queue and an increase queue of QUEUE_DEPTH words each.
// Every command word gives exactly one result word. Loads, seed pushes and
// light reads are latched, executed and then loaded into the result register,
// and the block takes one command at a time. A run command walks the decrease
// queue and then the increase queue from the grid memories: each queue entry
// is fetched and then latched (on the increase side its current level is then
// checked), each of its six directions is tested in turn, and each neighbour
// that lies in the section and is enabled gets a step of its own for its grid
// reads to return. An increase entry whose level no longer matches the cell
// skips its direction tests.
// The result word sits in an output register until taken, and the next
// command is accepted as soon as the result has been loaded there. Grids are
// not cleared by reset, though the queue pointers are; reading a cell that
// was never written returns an arbitrary level.

module voxel_block_light_propagation_top
    import vblp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16384
)
(
    input logic        clk,
    input logic        rst_n,
    vblp_in_if.sink    item,
    vblp_out_if.source result
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller owns the handshakes and the sequence of passes.
    vblp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds all grids, queues and the result word.
    vblp_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (item.opcode),
        .cell_index     (item.cell_index),
        .cell_value     (item.cell_value),
        .seed_flags     (item.seed_flags),
        .read_value     (result.read_value),
        .changed_count  (result.changed_count),
        .queue_overflow (result.queue_overflow),
        .run_done       (result.run_done)
    );

endmodule

### rtl/vblp_checker.sv
// Port-level checks of the voxel light block and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vblp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  read_value,
    input logic [19:0] changed_count,
    input logic        queue_overflow,
    input logic        run_done
);

    // A stalled result word stays offered with its changed count unchanged.
    `VBLP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `VBLP_ASSERT_NXT(a_count_hold, clk, rst_n, out_valid && !out_ready, $stable(changed_count))
    // A run result never carries read data.
    `VBLP_ASSERT_IMP(a_run_no_read, clk, rst_n, out_valid && run_done, read_value == 4'd0)
    // A result that reports a lost push keeps reporting it while it stays offered.
    `VBLP_ASSERT_NXT(a_ovf_sticky, clk, rst_n, out_valid && queue_overflow,
                     queue_overflow || !out_valid)

endmodule

bind voxel_block_light_propagation_top vblp_checker u_vblp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .read_value     (result.read_value),
    .changed_count  (result.changed_count),
    .queue_overflow (result.queue_overflow),
    .run_done       (result.run_done)
);

### tb/vblp_light_checker.sv
// Predicts the light block's result words and compares them with what comes out.
`timescale 1ns / 1ps

module vblp_light_checker
    import vblp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16384
)
(
    input logic  clk,
    input logic  rst_n,
    vblp_in_if   item,
    vblp_out_if  result,
    output int   fail_count,
    output int   pending_count
);

    typedef struct packed {
        logic [3:0]  read_value;
        logic [19:0] changed_count;
        logic        queue_overflow;
        logic        run_done;
    } light_result_t;

    logic [3:0]  light_cells [4096];
    logic [3:0]  opacity_cells [4096];
    logic [3:0]  source_cells [4096];
    logic [23:0] dim_queue [QUEUE_DEPTH];
    logic [23:0] glow_queue [QUEUE_DEPTH];
    int          dim_tail;
    int          glow_tail;
    logic [19:0] change_tally;
    logic        overflow_flag;
    light_result_t awaited_results[$];

    assign pending_count = awaited_results.size();

    function automatic int step_to(input int pos, input int dir);
        int x;
        int y;
        int z;
        x = pos % 16;
        z = (pos / 16) % 16;
        y = pos / 256;
        case (dir)
            0: x = x - 1;
            1: x = x + 1;
            2: y = y - 1;
            3: y = y + 1;
            4: z = z - 1;
            default: z = z + 1;
        endcase
        if (x < 0 || x > 15 || y < 0 || y > 15 || z < 0 || z > 15)
            return -1;
        return y * 256 + z * 16 + x;
    endfunction

    function automatic int reverse_dir(input int dir);
        return dir ^ 1;
    endfunction

    task automatic push_dim(input int pos, input logic [11:0] flags);
        if (dim_tail >= QUEUE_DEPTH)
        begin
            overflow_flag = 1'b1;
        end
        else
        begin
            dim_queue[dim_tail] = {pos[11:0], flags};
            dim_tail++;
        end
    endtask

    task automatic push_glow(input int pos, input logic [11:0] flags);
        if (glow_tail >= QUEUE_DEPTH)
        begin
            overflow_flag = 1'b1;
        end
        else
        begin
            glow_queue[glow_tail] = {pos[11:0], flags};
            glow_tail++;
        end
    endtask

    task automatic count_change();
        if (change_tally != COUNT_MAX)
            change_tally++;
    endtask

    // Dimming pass followed by the spreading pass, both breadth first.
    task automatic flood_light();
        int head;
        int pos;
        int lvl;
        int nb;
        int nl;
        int src;
        int cur;
        int op;
        int k;
        logic [11:0] fl;
        head = 0;
        while (head < dim_tail)
        begin
            pos = dim_queue[head][23:12];
            fl  = dim_queue[head][11:0];
            head++;
            lvl = fl[3:0];
            for (int d = 0; d < 6; d++)
            begin
                if (!fl[4 + d])
                    continue;
                nb = step_to(pos, d);
                if (nb < 0)
                    continue;
                nl = light_cells[nb];
                if (nl == 0)
                    continue;
                if (nl < lvl)
                begin
                    src = source_cells[nb];
                    light_cells[nb] = 4'd0;
                    count_change();
                    if (src < nl)
                        push_dim(nb, (12'(nl) | 12'h3F0) & ~(12'd1 << (4 + reverse_dir(d))));
                    if (src > 0)
                        push_glow(nb, 12'(src) | 12'h3F0 | 12'h800);
                end
                else
                begin
                    push_glow(nb, 12'(nl) | (12'd1 << (4 + reverse_dir(d))));
                end
            end
        end
        head = 0;
        while (head < glow_tail)
        begin
            pos = glow_queue[head][23:12];
            fl  = glow_queue[head][11:0];
            head++;
            lvl = fl[3:0];
            cur = light_cells[pos];
            if (fl[11] && cur < lvl)
            begin
                light_cells[pos] = 4'(lvl);
                cur = lvl;
                count_change();
            end
            if (cur != lvl)
                continue;
            for (int d = 0; d < 6; d++)
            begin
                if (!fl[4 + d])
                    continue;
                nb = step_to(pos, d);
                if (nb < 0)
                    continue;
                nl = light_cells[nb];
                if (lvl - 1 <= nl)
                    continue;
                op = opacity_cells[nb];
                if (op < 1)
                    op = 1;
                k = lvl - op;
                if (k > nl)
                begin
                    light_cells[nb] = 4'(k);
                    count_change();
                    if (k > 1)
                        push_glow(nb, (12'(k) | 12'h3F0) & ~(12'd1 << (4 + reverse_dir(d))));
                end
            end
        end
        dim_tail = 0;
        glow_tail = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        light_result_t want;
        light_result_t got;
        if (!rst_n)
        begin
            dim_tail = 0;
            glow_tail = 0;
            change_tally = '0;
            overflow_flag = 1'b0;
            fail_count = 0;
            awaited_results.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got = {result.read_value, result.changed_count,
                       result.queue_overflow, result.run_done};
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, got.read_value);
                        fail_count++;
                    end
                    if (got.changed_count !== want.changed_count)
                    begin
                        $display("%0t: changed_count expected %0d actual %0d",
                                 $time, want.changed_count, got.changed_count);
                        fail_count++;
                    end
                    if (got.queue_overflow !== want.queue_overflow)
                    begin
                        $display("%0t: queue_overflow expected %0d actual %0d",
                                 $time, want.queue_overflow, got.queue_overflow);
                        fail_count++;
                    end
                    if (got.run_done !== want.run_done)
                    begin
                        $display("%0t: run_done expected %0d actual %0d",
                                 $time, want.run_done, got.run_done);
                        fail_count++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                want = '0;
                case (item.opcode)
                    OP_WR_LIGHT:   light_cells[item.cell_index] = item.cell_value;
                    OP_WR_OPACITY: opacity_cells[item.cell_index] = item.cell_value;
                    OP_WR_SOURCE:  source_cells[item.cell_index] = item.cell_value;
                    OP_PUSH_DEC:   push_dim(item.cell_index, item.seed_flags);
                    OP_PUSH_INC:   push_glow(item.cell_index, item.seed_flags);
                    OP_RUN:
                    begin
                        change_tally = '0;
                        flood_light();
                        want.run_done = 1'b1;
                    end
                    OP_RD_LIGHT:   want.read_value = light_cells[item.cell_index];
                    default: ;
                endcase
                want.changed_count = change_tally;
                want.queue_overflow = overflow_flag;
                awaited_results.push_back(want);
            end
        end
    end

endmodule

### tb/tb_voxel_block_light_propagation_top.sv
// Stimulus, clocking and verdict for the voxel light propagation block.
`timescale 1ns / 1ps

module tb_voxel_block_light_propagation_top
    import vblp_pkg::*;
();

    localparam int QUEUE_DEPTH = 16384;
    // A run over a full queue with every neighbour visited stays well under this.
    localparam int IDLE_LIMIT = 2000000;
    localparam int RANDOM_WORDS = 1320;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   idle_cycles;
    bit   gaps_on;
    bit   stalls_on;
    int   stall_left;

    vblp_in_if  item_ch ();
    vblp_out_if result_ch ();

    voxel_block_light_propagation_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source)
    );

    vblp_light_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) light_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Free-running 2 ns clock.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The result side draws a fresh stall for every word it takes. The ready
    // line gets exactly one assignment per edge, so a zero stall keeps it high.
    initial
    begin
        result_ch.ready = 1'b0;
        stall_left = 0;
        stalls_on = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (result_ch.valid && result_ch.ready)
                begin
                    // Every so often switch between stalling and a clean stretch.
                    if ($urandom_range(0, 39) == 0)
                        stalls_on = !stalls_on;
                    stall_left = stalls_on ? $urandom_range(0, 12) : 0;
                end
                else if (stall_left > 0)
                begin
                    stall_left--;
                end
                result_ch.ready <= (stall_left == 0);
            end
        end
    end

    // The watchdog ends the run when no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL voxel_block_light_propagation_top");
            $finish;
        end
    end

    // Offers one command word, after a random gap while gaps are on, and holds it until taken.
    // Valid is only lowered during a gap, so back-to-back words keep it high.
    task automatic send_word(input logic [2:0] opcode, input logic [11:0] cell_index,
                             input logic [3:0] cell_value, input logic [11:0] seed_flags);
        int gap;
        gap = gaps_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.opcode     <= opcode;
        item_ch.cell_index <= cell_index;
        item_ch.cell_value <= cell_value;
        item_ch.seed_flags <= seed_flags;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    // Seed levels lean low so that most runs stay short, with the odd bright one.
    function automatic logic [11:0] seed_word();
        logic [11:0] flags;
        flags = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 3) != 0)
            flags[3:0] = 4'($urandom_range(0, 6));
        return flags;
    endfunction

    initial
    begin
        int pick;
        rst_n = 1'b0;
        gaps_on = 1'b1;
        item_ch.valid = 1'b0;
        item_ch.opcode = OP_RD_LIGHT;
        item_ch.cell_index = '0;
        item_ch.cell_value = '0;
        item_ch.seed_flags = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every cell of every grid is written first, so that no run or read
        // ever touches a cell that holds an arbitrary level.
        for (int c = 0; c < 4096; c++)
        begin
            send_word(OP_WR_LIGHT, 12'(c), 4'($urandom_range(0, 15)), '0);
            send_word(OP_WR_OPACITY, 12'(c), 4'($urandom_range(0, 15)), '0);
            send_word(OP_WR_SOURCE, 12'(c),
                      ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'd0, '0);
        end

        // Directed words: the corners of the section, extreme values, both
        // seed kinds with every direction, the force bit, and the unused opcode.
        send_word(OP_RD_LIGHT, 12'd0, 4'd0, '0);
        send_word(OP_RD_LIGHT, 12'd4095, 4'd0, '0);
        send_word(OP_WR_LIGHT, 12'd0, 4'd15, '0);
        send_word(OP_WR_OPACITY, 12'd1, 4'd0, '0);
        send_word(OP_WR_OPACITY, 12'd4094, 4'd15, '0);
        send_word(OP_WR_LIGHT, 12'd4095, 4'd0, '0);
        send_word(OP_RUN, 12'd0, 4'd0, '0);
        send_word(OP_PUSH_INC, 12'd0, 4'd0, 12'hBFF);
        send_word(OP_PUSH_INC, 12'd4095, 4'd0, 12'hFFF);
        send_word(OP_RUN, 12'd4095, 4'd15, 12'hFFF);
        send_word(OP_RD_LIGHT, 12'd1, 4'd0, '0);
        send_word(OP_RD_LIGHT, 12'd4094, 4'd0, '0);
        send_word(OP_PUSH_DEC, 12'd0, 4'd0, 12'h3FF);
        send_word(OP_PUSH_DEC, 12'd4095, 4'd0, 12'h7F0);
        send_word(OP_PUSH_INC, 12'd2048, 4'd0, 12'h40F);
        send_word(OP_RUN, 12'd0, 4'd0, '0);
        send_word(OP_RD_LIGHT, 12'd0, 4'd0, '0);
        send_word(OP_UNUSED, 12'd4095, 4'd15, 12'hFFF);
        send_word(OP_RD_LIGHT, 12'd2048, 4'd0, '0);

        // Random mix of loads, seeds, runs and reads with a run now and then.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 40 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 20)
                send_word(OP_WR_LIGHT, 12'($urandom_range(0, 4095)),
                          4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
            else if (pick < 30)
                send_word(OP_WR_OPACITY, 12'($urandom_range(0, 4095)),
                          4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
            else if (pick < 38)
                send_word(OP_WR_SOURCE, 12'($urandom_range(0, 4095)),
                          4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
            else if (pick < 55)
                send_word(OP_PUSH_DEC, 12'($urandom_range(0, 4095)),
                          4'($urandom_range(0, 15)), seed_word());
            else if (pick < 72)
                send_word(OP_PUSH_INC, 12'($urandom_range(0, 4095)),
                          4'($urandom_range(0, 15)), seed_word());
            else if (pick < 77)
                send_word(OP_RUN, 12'($urandom_range(0, 4095)),
                          4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
            else if (pick < 97)
                send_word(OP_RD_LIGHT, 12'($urandom_range(0, 4095)),
                          4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
            else
                send_word(OP_UNUSED, 12'($urandom_range(0, 4095)),
                          4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
        end

        // Queue full: one seed more than the queue holds, with no directions
        // enabled so the run that drains it stays cheap. The flag then sticks.
        gaps_on = 1'b0;
        send_word(OP_RUN, '0, '0, '0);
        for (int n = 0; n <= QUEUE_DEPTH; n++)
            send_word(OP_PUSH_DEC, 12'($urandom_range(0, 4095)), 4'd0,
                      {2'b00, 6'd0, 4'($urandom_range(0, 15))});
        send_word(OP_RUN, '0, '0, '0);
        send_word(OP_RD_LIGHT, 12'($urandom_range(0, 4095)), '0, '0);
        send_word(OP_RUN, '0, '0, '0);
        item_ch.valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS voxel_block_light_propagation_top");
        else
            $display("FAIL voxel_block_light_propagation_top");
        $finish;
    end

endmodule
